[hw/rtl/sfa_pkg.sv]
// Shared types, widths and codes for the feature statistics anomaly checker.
package sfa_pkg;

	// Table geometry
	localparam int NUM_FEATURES = 16;
	localparam int FIDX_W       = 4;
	localparam int WINDOW_DEPTH = 64;
	localparam int WIDX_W       = 6;
	localparam int WADDR_W      = FIDX_W + WIDX_W;
	localparam int WSTORE_DEPTH = NUM_FEATURES * WINDOW_DEPTH;

	// Field widths
	localparam int SAMPLE_W = 32;
	localparam int COUNT_W  = 32;
	localparam int MEAN_W   = 48;
	localparam int M2_W     = 64;
	localparam int FILL_W   = 7;
	localparam int CMD_W    = 3;
	localparam int SCORE_W  = 16;
	localparam int STATUS_W = 2;

	// Arithmetic unit widths
	localparam int DIVD_W  = 64;
	localparam int DIVS_W  = 32;
	localparam int MUL_W   = 64;
	localparam int PROD_W  = 2 * MUL_W;
	localparam int RNUM_W  = 96;
	localparam int RDEN_W  = 80;
	localparam int ROOT_W  = 16;
	localparam int RACC_W  = 114;

	// Commands
	localparam logic [CMD_W-1:0] CMD_ADD       = 3'd0;
	localparam logic [CMD_W-1:0] CMD_ZCHECK    = 3'd1;
	localparam logic [CMD_W-1:0] CMD_MACHECK   = 3'd2;
	localparam logic [CMD_W-1:0] CMD_READ      = 3'd3;
	localparam logic [CMD_W-1:0] CMD_CLEAR     = 3'd4;
	localparam logic [CMD_W-1:0] CMD_CLEAR_ALL = 3'd5;

	// Check status codes
	localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
	localparam logic [STATUS_W-1:0] ST_LOW_DATA = 2'd1;
	localparam logic [STATUS_W-1:0] ST_ZERO_VAR = 2'd2;

	// Check constants
	localparam logic [COUNT_W-1:0] MIN_COUNT      = 32'd10;
	localparam logic [SCORE_W-1:0] ZERO_VAR_SCORE = 16'd2560;
	localparam logic [SCORE_W-1:0] MA_LIMIT       = 16'd640;
	localparam logic [6:0]         CAP_RESET      = 7'd64;

	// One feature's statistics record
	typedef struct packed {
		logic [COUNT_W-1:0]  count;
		logic [MEAN_W-1:0]   mean;
		logic [M2_W-1:0]     m2;
		logic [SAMPLE_W-1:0] vmin;
		logic [SAMPLE_W-1:0] vmax;
		logic [FILL_W-1:0]   fill;
		logic [WIDX_W-1:0]   head;
	} feat_entry_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_LOAD,
		S_INIT,
		S_MEAN_GO,
		S_MEAN_WAIT,
		S_M2_GO,
		S_M2_WAIT,
		S_WIN_WR,
		S_VAR_GO,
		S_VAR_WAIT,
		S_Z_CHK,
		S_Z_MUL,
		S_MA_CHK,
		S_MA_RUN,
		S_MA_SQ,
		S_MA_SQW,
		S_MA_B,
		S_MA_AW,
		S_ROOT_GO,
		S_ROOT_WAIT,
		S_FINISH
	} state_t;

endpackage

[hw/rtl/feature_stats_anomaly_check.sv]
// Top level: feature statistics table, window store and command sequencer.
//
//  channel  | direction | handshake            | payload
//  ---------+-----------+----------------------+-------------------------------------------
//  cfg      | in        | cfg_wr_en            | cfg_wr_data (window capacity)
//  in       | in        | in_valid / in_stall  | command, feature_index, sample_value, ...
//  out      | out       | out_valid / out_stall| is_anomaly, anomaly_score, baseline_*, ...
//
// One command at a time. A read or a short-history check of a feature with two or more samples
// runs the bit-serial variance divide; clears, absent features and first samples use no unit; a
// later add runs the mean divide, M2 multiply and variance divide; a z-score check adds a multiply
// and the root search; a moving-average check adds a walk over n window samples, multiplies and the root.
// Reset clears the feature valid bits at once; there is no clearing pass.
// The input stalls until the result is loaded; a waiting output beat holds only that load.
module feature_stats_anomaly_check (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [6:0]  cfg_wr_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  command,
	input  logic [3:0]  feature_index,
	input  logic [31:0] sample_value,
	input  logic [15:0] z_threshold,
	input  logic [6:0]  window_length,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        is_anomaly,
	output logic [15:0] anomaly_score,
	output logic [1:0]  check_status,
	output logic [31:0] sample_count,
	output logic [31:0] baseline_mean,
	output logic [31:0] baseline_variance,
	output logic [31:0] baseline_min,
	output logic [31:0] baseline_max
);

	localparam int NF  = sfa_pkg::NUM_FEATURES;
	localparam int FW  = sfa_pkg::FIDX_W;
	localparam int SW  = sfa_pkg::SAMPLE_W;
	localparam int MW  = sfa_pkg::MEAN_W;

	sfa_pkg::state_t state_q, state_d, tail_st;

	// Memories
	sfa_pkg::feat_entry_t feat_mem [NF];
	sfa_pkg::feat_entry_t feat_rd_q;
	logic [SW-1:0]        win_mem [sfa_pkg::WSTORE_DEPTH];
	logic [SW-1:0]        win_rdata_q;
	logic [sfa_pkg::WADDR_W-1:0] win_waddr, win_raddr;

	// Control and item registers
	logic [6:0]   cap_q;
	logic [NF-1:0] valid_q;
	logic         out_valid_q;
	logic [2:0]   cmd_q;
	logic [FW-1:0] fidx_q;
	logic [SW-1:0] x_q;
	logic [15:0]  thr_q;
	logic [6:0]   n_q;
	logic         present_q;
	sfa_pkg::feat_entry_t ent_q, ent_wr;
	logic [MW:0]  d1_q;
	logic [63:0]  var_q;
	logic         anom_q;
	logic [15:0]  score_q;
	logic [1:0]   status_q;

	// Window walk
	logic [6:0]   k_q;
	logic         rd_v_s1, v_s2;
	logic [63:0]  sq_s2;
	logic [SW-1:0] val_s2;
	logic [38:0]  sum_q;
	logic [69:0]  sq_sum_q;
	logic [76:0]  qn_q;
	logic [79:0]  b_q;
	logic [sfa_pkg::RNUM_W-1:0] rnum_q;
	logic [sfa_pkg::RDEN_W-1:0] rden_q;

	// Unit connections
	logic                       div_start, div_done;
	logic [sfa_pkg::DIVD_W-1:0] div_dvd, div_quo;
	logic [sfa_pkg::DIVS_W-1:0] div_dsr;
	logic                       mul_start, mul_done;
	logic [sfa_pkg::MUL_W-1:0]  mul_a, mul_b;
	logic [sfa_pkg::PROD_W-1:0] mul_prod;
	logic                       root_start, root_done;
	logic [sfa_pkg::ROOT_W-1:0] root_s;
	logic                       feat_we, win_we;

	// Combinational helpers
	logic         accept, in_range, out_free;
	logic [MW-1:0] xq;
	logic [MW:0]  d_now, d_mag, d1_mag;
	logic [MW:0]  q49, mean49;
	logic [31:0]  cnt_inc;
	logic [63:0]  m2_inc;
	logic [64:0]  m2_sum;
	logic [6:0]   cap_eff;
	logic [7:0]   fill_p1;
	logic [SW-1:0] rd_mag;
	logic [38:0]  sum_mag;
	logic [39:0]  xn, a_diff, a_mag;
	logic [76:0]  qn;
	logic         z_low, ma_low, var_go;

	sfa_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .dividend(div_dvd),
		.divisor(div_dsr), .done(div_done), .quotient(div_quo)
	);

	sfa_mul u_mul (
		.clk(clk), .arst_n(arst_n), .start(mul_start), .a(mul_a), .b(mul_b),
		.done(mul_done), .product(mul_prod)
	);

	sfa_root u_root (
		.clk(clk), .arst_n(arst_n), .start(root_start), .num(rnum_q), .den(rden_q),
		.done(root_done), .root(root_s)
	);

	assign in_stall = (state_q != sfa_pkg::S_IDLE);
	assign accept   = in_valid && !in_stall;
	assign in_range = (int'(fidx_q) < NF);
	assign out_free = !out_valid_q || !out_stall;

	// Arithmetic on the working record
	always_comb begin
		xq      = {x_q, 16'b0};
		d_now   = {xq[MW-1], xq} - {ent_q.mean[MW-1], ent_q.mean};
		d_mag   = d_now[MW] ? ((MW+1)'(0) - d_now) : d_now;
		d1_mag  = d1_q[MW] ? ((MW+1)'(0) - d1_q) : d1_q;
		q49     = div_quo[MW:0];
		mean49  = {ent_q.mean[MW-1], ent_q.mean} + (d1_q[MW] ? ((MW+1)'(0) - q49) : q49);
		cnt_inc = (ent_q.count == '1) ? ent_q.count : ent_q.count + 32'd1;
		m2_inc  = (mul_prod[127:112] != '0) ? '1 : mul_prod[111:48];
		m2_sum  = {1'b0, ent_q.m2} + {1'b0, m2_inc};
		cap_eff = (cap_q > 7'(sfa_pkg::WINDOW_DEPTH)) ? 7'(sfa_pkg::WINDOW_DEPTH) : cap_q;
		fill_p1 = {1'b0, ent_q.fill} + 8'd1;
		ent_wr      = ent_q;
		ent_wr.head = ent_q.head + 1'b1;
		ent_wr.fill = (fill_p1 > {1'b0, cap_eff}) ? cap_eff : fill_p1[6:0];
		rd_mag  = win_rdata_q[SW-1] ? (SW'(0) - win_rdata_q) : win_rdata_q;
		sum_mag = sum_q[38] ? (39'd0 - sum_q) : sum_q;
		xn      = $signed(x_q) * $signed({1'b0, n_q});
		a_diff  = xn - {sum_q[38], sum_q};
		a_mag   = a_diff[39] ? (40'd0 - a_diff) : a_diff;
		qn      = 77'(sq_sum_q) * 77'(n_q);
		z_low   = !present_q || (ent_q.count < sfa_pkg::MIN_COUNT);
		ma_low  = !present_q || (n_q == '0) || (n_q > ent_q.fill);
		var_go  = present_q && (ent_q.count >= 32'd2);
		win_waddr = {fidx_q, ent_q.head};
		win_raddr = {fidx_q, ent_q.head - 1'b1 - k_q[5:0]};
	end

	// Where a command goes once the variance is known
	always_comb begin
		case (cmd_q)
			sfa_pkg::CMD_ZCHECK:  tail_st = sfa_pkg::S_Z_CHK;
			sfa_pkg::CMD_MACHECK: tail_st = sfa_pkg::S_MA_CHK;
			default:              tail_st = sfa_pkg::S_FINISH;
		endcase
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			sfa_pkg::S_IDLE:      if (accept) state_d = sfa_pkg::S_LOAD;
			sfa_pkg::S_LOAD: begin
				if (cmd_q == sfa_pkg::CMD_ADD && in_range)
					state_d = valid_q[fidx_q] ? sfa_pkg::S_MEAN_GO : sfa_pkg::S_INIT;
				else
					state_d = sfa_pkg::S_VAR_GO;
			end
			sfa_pkg::S_INIT:      state_d = sfa_pkg::S_WIN_WR;
			sfa_pkg::S_MEAN_GO:   state_d = sfa_pkg::S_MEAN_WAIT;
			sfa_pkg::S_MEAN_WAIT: if (div_done) state_d = sfa_pkg::S_M2_GO;
			sfa_pkg::S_M2_GO:     state_d = sfa_pkg::S_M2_WAIT;
			sfa_pkg::S_M2_WAIT:   if (mul_done) state_d = sfa_pkg::S_WIN_WR;
			sfa_pkg::S_WIN_WR:    state_d = sfa_pkg::S_VAR_GO;
			sfa_pkg::S_VAR_GO:    state_d = var_go ? sfa_pkg::S_VAR_WAIT : tail_st;
			sfa_pkg::S_VAR_WAIT:  if (div_done) state_d = tail_st;
			sfa_pkg::S_Z_CHK: begin
				if (z_low || var_q == '0)
					state_d = sfa_pkg::S_FINISH;
				else
					state_d = sfa_pkg::S_Z_MUL;
			end
			sfa_pkg::S_Z_MUL:     if (mul_done) state_d = sfa_pkg::S_ROOT_GO;
			sfa_pkg::S_MA_CHK:    state_d = ma_low ? sfa_pkg::S_FINISH : sfa_pkg::S_MA_RUN;
			sfa_pkg::S_MA_RUN:    if (k_q == n_q && !rd_v_s1 && !v_s2) state_d = sfa_pkg::S_MA_SQ;
			sfa_pkg::S_MA_SQ:     state_d = sfa_pkg::S_MA_SQW;
			sfa_pkg::S_MA_SQW:    if (mul_done) state_d = sfa_pkg::S_MA_B;
			sfa_pkg::S_MA_B:      state_d = (b_q == '0) ? sfa_pkg::S_FINISH : sfa_pkg::S_MA_AW;
			sfa_pkg::S_MA_AW:     if (mul_done) state_d = sfa_pkg::S_ROOT_GO;
			sfa_pkg::S_ROOT_GO:   state_d = sfa_pkg::S_ROOT_WAIT;
			sfa_pkg::S_ROOT_WAIT: if (root_done) state_d = sfa_pkg::S_FINISH;
			sfa_pkg::S_FINISH:    if (out_free) state_d = sfa_pkg::S_IDLE;
			default:              state_d = sfa_pkg::S_IDLE;
		endcase
	end

	// Unit strobes and operands
	always_comb begin
		div_start  = 1'b0;
		div_dvd    = ent_q.m2;
		div_dsr    = ent_q.count - 32'd1;
		mul_start  = 1'b0;
		mul_a      = 64'(d_mag);
		mul_b      = 64'(d_mag);
		root_start = 1'b0;
		feat_we    = 1'b0;
		win_we     = 1'b0;
		unique case (state_q)
			sfa_pkg::S_MEAN_GO: begin
				div_start = 1'b1;
				div_dvd   = 64'(d_mag);
				div_dsr   = cnt_inc;
			end
			sfa_pkg::S_M2_GO: begin
				mul_start = 1'b1;
				mul_a     = 64'(d1_mag);
			end
			sfa_pkg::S_WIN_WR: begin
				feat_we = 1'b1;
				win_we  = 1'b1;
			end
			sfa_pkg::S_VAR_GO:  div_start = var_go;
			sfa_pkg::S_Z_CHK:   mul_start = !z_low && (var_q != '0);
			sfa_pkg::S_MA_SQ: begin
				mul_start = 1'b1;
				mul_a     = 64'(sum_mag);
				mul_b     = 64'(sum_mag);
			end
			sfa_pkg::S_MA_B: begin
				mul_start = (b_q != '0);
				mul_a     = 64'(a_mag);
				mul_b     = 64'(a_mag);
			end
			sfa_pkg::S_ROOT_GO: root_start = 1'b1;
			default: ;
		endcase
	end

	// Feature table: read at the accepted index, write back after an add
	always_ff @(posedge clk) begin
		if (feat_we)
			feat_mem[fidx_q] <= ent_wr;
		feat_rd_q <= feat_mem[feature_index];
	end

	// Window store
	always_ff @(posedge clk) begin
		if (win_we)
			win_mem[win_waddr] <= x_q;
		win_rdata_q <= win_mem[win_raddr];
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= sfa_pkg::S_IDLE;
			cap_q       <= sfa_pkg::CAP_RESET;
			valid_q     <= '0;
			out_valid_q <= 1'b0;
			rd_v_s1     <= 1'b0;
			v_s2        <= 1'b0;
			k_q         <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_wr_en)
				cap_q <= cfg_wr_data;
			// Clear or mark features
			if (state_q == sfa_pkg::S_LOAD) begin
				if (cmd_q == sfa_pkg::CMD_CLEAR && in_range)
					valid_q[fidx_q] <= 1'b0;
				else if (cmd_q == sfa_pkg::CMD_CLEAR_ALL)
					valid_q <= '0;
			end
			if (state_q == sfa_pkg::S_WIN_WR)
				valid_q[fidx_q] <= 1'b1;
			// Walk the window: issue, read, square
			if (state_q == sfa_pkg::S_MA_CHK) begin
				k_q     <= '0;
				rd_v_s1 <= 1'b0;
				v_s2    <= 1'b0;
			end else if (state_q == sfa_pkg::S_MA_RUN) begin
				rd_v_s1 <= (k_q != n_q);
				v_s2    <= rd_v_s1;
				if (k_q != n_q)
					k_q <= k_q + 7'd1;
			end
			// Output beat
			if (state_q == sfa_pkg::S_FINISH && out_free)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			sfa_pkg::S_IDLE: begin
				if (accept) begin
					cmd_q    <= command;
					fidx_q   <= feature_index;
					x_q      <= sample_value;
					thr_q    <= z_threshold;
					n_q      <= window_length;
					anom_q   <= 1'b0;
					score_q  <= '0;
					status_q <= sfa_pkg::ST_OK;
				end
			end
			sfa_pkg::S_LOAD: begin
				ent_q <= feat_rd_q;
				case (cmd_q) inside
					sfa_pkg::CMD_CLEAR, sfa_pkg::CMD_CLEAR_ALL: present_q <= 1'b0;
					default: present_q <= in_range && valid_q[fidx_q];
				endcase
				case (cmd_q) inside
					sfa_pkg::CMD_ADD, sfa_pkg::CMD_ZCHECK, sfa_pkg::CMD_MACHECK,
					sfa_pkg::CMD_CLEAR, sfa_pkg::CMD_CLEAR_ALL: ;
					default: if (!(in_range && valid_q[fidx_q])) status_q <= sfa_pkg::ST_LOW_DATA;
				endcase
			end
			sfa_pkg::S_INIT: begin
				ent_q.count <= 32'd1;
				ent_q.mean  <= xq;
				ent_q.m2    <= '0;
				ent_q.vmin  <= x_q;
				ent_q.vmax  <= x_q;
				ent_q.fill  <= '0;
				ent_q.head  <= '0;
			end
			sfa_pkg::S_MEAN_GO: begin
				ent_q.count <= cnt_inc;
				d1_q        <= d_now;
			end
			sfa_pkg::S_MEAN_WAIT: begin
				if (div_done)
					ent_q.mean <= mean49[MW-1:0];
			end
			sfa_pkg::S_M2_WAIT: begin
				if (mul_done) begin
					ent_q.m2 <= m2_sum[64] ? '1 : m2_sum[63:0];
					if ($signed(x_q) < $signed(ent_q.vmin))
						ent_q.vmin <= x_q;
					if ($signed(x_q) > $signed(ent_q.vmax))
						ent_q.vmax <= x_q;
				end
			end
			sfa_pkg::S_WIN_WR: begin
				ent_q     <= ent_wr;
				present_q <= 1'b1;
			end
			sfa_pkg::S_VAR_GO: begin
				if (!var_go)
					var_q <= '0;
			end
			sfa_pkg::S_VAR_WAIT: begin
				if (div_done)
					var_q <= div_quo;
			end
			sfa_pkg::S_Z_CHK: begin
				if (z_low) begin
					status_q <= sfa_pkg::ST_LOW_DATA;
				end else if (var_q == '0) begin
					status_q <= sfa_pkg::ST_ZERO_VAR;
					anom_q   <= (d_now != '0);
					score_q  <= (d_now != '0) ? sfa_pkg::ZERO_VAR_SCORE : '0;
				end
			end
			sfa_pkg::S_Z_MUL: begin
				if (mul_done) begin
					rnum_q <= {30'b0, mul_prod[97:32]};
					rden_q <= {16'b0, var_q};
				end
			end
			sfa_pkg::S_MA_CHK: begin
				sum_q    <= '0;
				sq_sum_q <= '0;
				if (ma_low)
					status_q <= sfa_pkg::ST_LOW_DATA;
			end
			sfa_pkg::S_MA_RUN: begin
				if (rd_v_s1) begin
					sq_s2  <= rd_mag * rd_mag;
					val_s2 <= win_rdata_q;
				end
				if (v_s2) begin
					sum_q    <= sum_q + {{7{val_s2[SW-1]}}, val_s2};
					sq_sum_q <= sq_sum_q + 70'(sq_s2);
				end
			end
			sfa_pkg::S_MA_SQ:  qn_q <= qn;
			sfa_pkg::S_MA_SQW: begin
				if (mul_done)
					b_q <= 80'(qn_q) - mul_prod[79:0];
			end
			sfa_pkg::S_MA_B: begin
				if (b_q == '0)
					status_q <= sfa_pkg::ST_ZERO_VAR;
			end
			sfa_pkg::S_MA_AW: begin
				if (mul_done) begin
					rnum_q <= {mul_prod[79:0], 16'b0};
					rden_q <= b_q;
				end
			end
			sfa_pkg::S_ROOT_WAIT: begin
				if (root_done) begin
					score_q <= root_s;
					anom_q  <= (cmd_q == sfa_pkg::CMD_ZCHECK) ? (root_s > thr_q)
					                                          : (root_s > sfa_pkg::MA_LIMIT);
				end
			end
			default: ;
		endcase
	end

	// Result register: load the finished beat once the slot is free
	always_ff @(posedge clk) begin
		if (state_q == sfa_pkg::S_FINISH && out_free) begin
			is_anomaly    <= anom_q;
			anomaly_score <= score_q;
			check_status  <= status_q;
			if (present_q) begin
				sample_count      <= ent_q.count;
				baseline_mean     <= ent_q.mean[MW-1:16];
				baseline_variance <= (var_q[63:32] != '0) ? '1 : var_q[31:0];
				baseline_min      <= ent_q.vmin;
				baseline_max      <= ent_q.vmax;
			end else begin
				sample_count      <= '0;
				baseline_mean     <= '0;
				baseline_variance <= '0;
				baseline_min      <= '0;
				baseline_max      <= '0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

[hw/rtl/sfa_div.sv]
// Restoring unsigned divider, one quotient bit per cycle.
module sfa_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [sfa_pkg::DIVD_W-1:0] dividend,
	input  logic [sfa_pkg::DIVS_W-1:0] divisor,
	output logic                       done,
	output logic [sfa_pkg::DIVD_W-1:0] quotient
);

	localparam int CNT_W = $clog2(sfa_pkg::DIVD_W);

	logic                       busy_q;
	logic                       done_q;
	logic [CNT_W-1:0]           cnt_q;
	logic [sfa_pkg::DIVD_W-1:0] quo_q;
	logic [sfa_pkg::DIVS_W-1:0] rem_q;
	logic [sfa_pkg::DIVS_W-1:0] dsr_q;
	logic [sfa_pkg::DIVS_W:0]   rem_sh;
	logic                       ge;
	logic [sfa_pkg::DIVS_W:0]   rem_nx;

	// Shift in the next dividend bit and trial subtract
	always_comb begin
		rem_sh = {rem_q, quo_q[sfa_pkg::DIVD_W-1]};
		ge     = rem_sh >= {1'b0, dsr_q};
		rem_nx = ge ? (rem_sh - {1'b0, dsr_q}) : rem_sh;
	end

	// Control: count the bit steps
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(sfa_pkg::DIVD_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: quotient bits enter where the dividend leaves
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[sfa_pkg::DIVD_W-2:0], ge};
			rem_q <= rem_nx[sfa_pkg::DIVS_W-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

[hw/rtl/sfa_mul.sv]
// Wide unsigned multiplier built from four registered 32x32 partial products.
module sfa_mul (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [sfa_pkg::MUL_W-1:0]  a,
	input  logic [sfa_pkg::MUL_W-1:0]  b,
	output logic                       done,
	output logic [sfa_pkg::PROD_W-1:0] product
);

	localparam int HW = sfa_pkg::MUL_W / 2;

	logic                       busy_q;
	logic                       done_q;
	logic [2:0]                 step_q;
	logic [sfa_pkg::MUL_W-1:0]  a_q;
	logic [sfa_pkg::MUL_W-1:0]  b_q;
	logic [sfa_pkg::MUL_W-1:0]  pp_q;
	logic                       pp_v_q;
	logic [1:0]                 pp_sh_q;
	logic [sfa_pkg::PROD_W-1:0] acc_q;
	logic [HW-1:0]              op_a;
	logic [HW-1:0]              op_b;
	logic [1:0]                 op_sh;
	logic [sfa_pkg::PROD_W-1:0] pp_al;

	// Pick the halves for this step
	always_comb begin
		case (step_q)
			3'd0: begin
				op_a = a_q[HW-1:0];  op_b = b_q[HW-1:0];  op_sh = 2'd0;
			end
			3'd1: begin
				op_a = a_q[HW-1:0];  op_b = b_q[2*HW-1:HW]; op_sh = 2'd1;
			end
			3'd2: begin
				op_a = a_q[2*HW-1:HW]; op_b = b_q[HW-1:0];  op_sh = 2'd1;
			end
			default: begin
				op_a = a_q[2*HW-1:HW]; op_b = b_q[2*HW-1:HW]; op_sh = 2'd2;
			end
		endcase
	end

	// Align the registered partial product
	always_comb begin
		case (pp_sh_q)
			2'd0:    pp_al = {{HW{1'b0}}, {HW{1'b0}}, pp_q};
			2'd1:    pp_al = {{HW{1'b0}}, pp_q, {HW{1'b0}}};
			default: pp_al = {pp_q, {HW{1'b0}}, {HW{1'b0}}};
		endcase
	end

	// Control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
			pp_v_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
				pp_v_q <= 1'b0;
			end else if (busy_q) begin
				if (step_q != 3'd4) begin
					step_q <= step_q + 3'd1;
					pp_v_q <= 1'b1;
				end else begin
					pp_v_q <= 1'b0;
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: register each partial product, then add it into the accumulator
	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= a;
			b_q   <= b;
			acc_q <= '0;
		end else if (busy_q) begin
			pp_q    <= op_a * op_b;
			pp_sh_q <= op_sh;
			if (pp_v_q)
				acc_q <= acc_q + pp_al;
		end
	end

	assign done    = done_q;
	assign product = acc_q;

endmodule

[hw/rtl/sfa_root.sv]
// Bit-serial search for the largest s with s*s*den <= num, one bit per cycle.
module sfa_root (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [sfa_pkg::RNUM_W-1:0] num,
	input  logic [sfa_pkg::RDEN_W-1:0] den,
	output logic                       done,
	output logic [sfa_pkg::ROOT_W-1:0] root
);

	localparam int AW    = sfa_pkg::RACC_W;
	localparam int BIT_W = $clog2(sfa_pkg::ROOT_W);

	logic                       busy_q;
	logic                       done_q;
	logic [BIT_W-1:0]           bit_q;
	logic [AW-1:0]              num_q;
	logic [AW-1:0]              t_q;   // den * s^2
	logic [AW-1:0]              v_q;   // den * s shifted up by bit + 1
	logic [AW-1:0]              p_q;   // den shifted up by twice the bit
	logic [sfa_pkg::ROOT_W-1:0] s_q;
	logic [AW-1:0]              cand;
	logic                       take;

	// Trial value den * (s + 2^bit)^2
	always_comb begin
		cand = t_q + v_q + p_q;
		take = cand <= num_q;
	end

	// Control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			bit_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				bit_q  <= BIT_W'(sfa_pkg::ROOT_W - 1);
			end else if (busy_q) begin
				bit_q <= bit_q - 1'b1;
				if (bit_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: keep the shifted terms up to date without a barrel shifter
	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= AW'(num);
			t_q   <= '0;
			v_q   <= '0;
			p_q   <= AW'(den) << (2 * (sfa_pkg::ROOT_W - 1));
			s_q   <= '0;
		end else if (busy_q) begin
			s_q <= {s_q[sfa_pkg::ROOT_W-2:0], take};
			p_q <= p_q >> 2;
			if (take) begin
				t_q <= cand;
				v_q <= (v_q >> 1) + p_q;
			end else begin
				v_q <= v_q >> 1;
			end
		end
	end

	assign done = done_q;
	assign root = s_q;

endmodule
